FILE: design/ctab_pkg.sv
package ctab_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int MAX_LEN_DEF = 255;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;
	localparam logic [1:0] REQ_COUNT  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_NAME  = 3'd1;
	localparam logic [2:0] ST_BAD_PASS  = 3'd2;
	localparam logic [2:0] ST_DUPLICATE = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;
	localparam logic [2:0] ST_WRONG     = 3'd6;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_NAME,
		PH_PASS
	} phase_t;

	typedef enum logic {
		CS_TAKE,
		CS_EVAL
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic eval;
	} ctab_cmd_t;

	typedef struct packed {
		logic emit;
	} ctab_stat_t;

endpackage

FILE: design/ctab_ctrl.sv
module ctab_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output ctab_pkg::ctab_cmd_t cmd,
	input  ctab_pkg::ctab_stat_t stat
);

	ctab_pkg::ctrl_state_t state_q, state_d;
	logic out_valid_q, out_valid_d;
	logic out_free;

	// hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ctab_pkg::CS_TAKE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// sequence take and evaluate, evaluate only when the output slot is free
	always_comb begin
		out_free    = !out_valid_q || !out_stall;
		state_d     = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		out_valid_d = out_valid_q && out_stall;
		case (state_q)
			ctab_pkg::CS_TAKE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ctab_pkg::CS_EVAL;
				end
			end
			ctab_pkg::CS_EVAL: begin
				if (out_free) begin
					cmd.eval = 1'b1;
					state_d  = ctab_pkg::CS_TAKE;
					if (stat.emit) out_valid_d = 1'b1;
				end
			end
			default: state_d = ctab_pkg::CS_TAKE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_take_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ctab_pkg::CS_EVAL)
		else $error("accepted transaction not evaluated");
	a_eval_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ctab_pkg::CS_EVAL && out_valid_q && out_stall |=> state_q == ctab_pkg::CS_EVAL)
		else $error("evaluation ran over a pending result");
	a_eval_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ctab_pkg::CS_EVAL |-> in_stall)
		else $error("input taken during evaluation");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("result dropped while stalled");

endmodule

FILE: design/ctab_dp.sv
module ctab_dp #(
	parameter int ENTRIES = ctab_pkg::ENTRIES_DEF,
	parameter int MAX_LEN = ctab_pkg::MAX_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctab_pkg::ctab_cmd_t  cmd,
	output ctab_pkg::ctab_stat_t stat,
	input  logic [1:0]           req_type,
	input  logic [7:0]           data_byte,
	input  logic                 empty_part,
	input  logic                 last_of_part,
	output logic                 ok,
	output logic [2:0]           status,
	output logic [4:0]           user_count
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UW = $clog2(ENTRIES + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [7:0] MAXL = 8'(MAX_LEN);

	// request state
	ctab_pkg::phase_t     phase_q, phase_d, ph;
	logic [1:0]           kind_q, kind_d, kind;
	logic [ENTRIES-1:0]   match_q, match_d, valid_q, valid_d, m0, m1, m2;
	logic [7:0]           pos_q, pos_d, pos0, pos1;
	logic                 ovf_q, ovf_d, ovf0, ovf1;
	logic                 found_q, found_d, found0, bad_q, bad_d, bad0;
	logic [UW-1:0]        users_q, users_d;

	// latched item
	logic [1:0] type_q;
	logic [7:0] b_q;
	logic       empty_q, last_q;

	// banks and lengths
	logic [7:0] rd_name_q [ENTRIES];
	logic [7:0] rd_pass_q [ENTRIES];
	logic [7:0] name_len_q [ENTRIES];
	logic [7:0] pass_len_q [ENTRIES];
	logic [AW-1:0] raddr, waddr;

	logic          start, pass, count, endp, fnd, bd, have_free, any2;
	logic [IW-1:0] slot, idx;
	logic          wr_name_en, wr_pass_en, wr_nlen_en, wr_plen_en;
	logic          ok_d;
	logic [2:0]    status_d;
	logic [31:0]   users_ext;
	logic [7:0]    len_i, s_i;

	logic       ok_q;
	logic [2:0] status_q;
	logic [4:0] count_q;

	assign raddr = (phase_q == ctab_pkg::PH_IDLE || pos_q >= MAXL) ? '0 : pos_q[AW-1:0];

	// find lowest free slot
	always_comb begin
		have_free = 1'b0;
		slot      = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				have_free = 1'b1;
				slot      = IW'(i);
			end
		end
	end

	// evaluate one item
	always_comb begin
		start  = (phase_q == ctab_pkg::PH_IDLE);
		kind   = start ? type_q : kind_q;
		ph     = start ? ctab_pkg::PH_NAME : phase_q;
		m0     = start ? valid_q : match_q;
		pos0   = start ? 8'd0 : pos_q;
		ovf0   = start ? 1'b0 : ovf_q;
		found0 = start ? 1'b0 : found_q;
		bad0   = start ? 1'b0 : bad_q;
		pass   = (ph == ctab_pkg::PH_PASS);
		count  = start && (type_q == ctab_pkg::REQ_COUNT);
		endp   = empty_q || last_q;
		waddr  = pos0[AW-1:0];
		len_i  = '0;
		s_i    = '0;

		// compare the byte against every live entry
		m1         = m0;
		pos1       = pos0;
		ovf1       = ovf0;
		wr_name_en = 1'b0;
		wr_pass_en = 1'b0;
		if (!empty_q) begin
			if (pos0 >= MAXL) begin
				ovf1 = 1'b1;
				m1   = '0;
			end else begin
				for (int i = 0; i < ENTRIES; i++) begin
					len_i = pass ? pass_len_q[i] : name_len_q[i];
					s_i   = pass ? rd_pass_q[i] : rd_name_q[i];
					m1[i] = m0[i] && (pos0 < len_i) && (s_i == b_q);
				end
				wr_name_en = cmd.eval && !count && kind == ctab_pkg::REQ_ADD && have_free && !pass;
				wr_pass_en = cmd.eval && !count && kind == ctab_pkg::REQ_ADD && have_free && pass;
				pos1 = pos0 + 8'd1;
			end
		end

		// close the part on length
		for (int i = 0; i < ENTRIES; i++) begin
			len_i = pass ? pass_len_q[i] : name_len_q[i];
			m2[i] = m1[i] && !ovf1 && (len_i == pos1);
		end
		wr_nlen_en = cmd.eval && !count && endp && kind == ctab_pkg::REQ_ADD && have_free && !pass;
		wr_plen_en = cmd.eval && !count && endp && kind == ctab_pkg::REQ_ADD && have_free && pass;

		any2 = |m2;
		idx  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (m2[i]) idx = IW'(i);
		end
		fnd = any2;
		bd  = ovf1 || pos1 == 8'd0;

		phase_d   = ph;
		kind_d    = kind;
		match_d   = m1;
		pos_d     = pos1;
		ovf_d     = ovf1;
		found_d   = found0;
		bad_d     = bad0;
		valid_d   = valid_q;
		users_d   = users_q;
		stat.emit = 1'b0;
		ok_d      = 1'b0;
		status_d  = ctab_pkg::ST_OK;

		if (count) begin
			phase_d   = ctab_pkg::PH_IDLE;
			match_d   = match_q;
			pos_d     = pos_q;
			ovf_d     = ovf_q;
			found_d   = found_q;
			bad_d     = bad_q;
			stat.emit = 1'b1;
			ok_d      = 1'b1;
		end else if (endp) begin
			match_d = m2;
			if (ph == ctab_pkg::PH_NAME) begin
				found_d = fnd;
				bad_d   = bd;
				if (kind == ctab_pkg::REQ_REMOVE) begin
					phase_d   = ctab_pkg::PH_IDLE;
					stat.emit = 1'b1;
					if (fnd) begin
						valid_d[idx] = 1'b0;
						if (users_q != '0) users_d = users_q - UW'(1);
						ok_d = 1'b1;
					end else begin
						status_d = ctab_pkg::ST_NOT_FOUND;
					end
				end else begin
					phase_d = ctab_pkg::PH_PASS;
					pos_d   = 8'd0;
					ovf_d   = 1'b0;
				end
			end else begin
				phase_d   = ctab_pkg::PH_IDLE;
				stat.emit = 1'b1;
				if (kind == ctab_pkg::REQ_LOOKUP) begin
					if (!found0)   status_d = ctab_pkg::ST_NOT_FOUND;
					else if (any2) ok_d = 1'b1;
					else           status_d = ctab_pkg::ST_WRONG;
				end else if (bad0) begin
					status_d = ctab_pkg::ST_BAD_NAME;
				end else if (ovf1 || pos1 == 8'd0) begin
					status_d = ctab_pkg::ST_BAD_PASS;
				end else if (found0) begin
					status_d = ctab_pkg::ST_DUPLICATE;
				end else if (!have_free) begin
					status_d = ctab_pkg::ST_FULL;
				end else begin
					valid_d[slot] = 1'b1;
					users_d       = users_q + UW'(1);
					ok_d          = 1'b1;
				end
			end
		end
		users_ext = 32'(users_d);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ctab_pkg::PH_IDLE;
			kind_q  <= ctab_pkg::REQ_ADD;
			match_q <= '0;
			valid_q <= '0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
			found_q <= 1'b0;
			bad_q   <= 1'b0;
			users_q <= '0;
		end else if (cmd.eval) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			match_q <= match_d;
			valid_q <= valid_d;
			pos_q   <= pos_d;
			ovf_q   <= ovf_d;
			found_q <= found_d;
			bad_q   <= bad_d;
			users_q <= users_d;
		end
	end

	// latch the item and the result payload
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			type_q  <= req_type;
			b_q     <= data_byte;
			empty_q <= empty_part;
			last_q  <= last_of_part;
		end
		if (cmd.eval && stat.emit) begin
			ok_q     <= ok_d;
			status_q <= status_d;
			count_q  <= users_ext[4:0];
		end
	end

	// one name bank and one password bank per entry
	for (genvar e = 0; e < ENTRIES; e++) begin : g_bank
		logic [7:0] name_mem [MAX_LEN];
		logic [7:0] pass_mem [MAX_LEN];

		always_ff @(posedge clk) begin
			if (wr_name_en && slot == IW'(e)) name_mem[waddr] <= b_q;
			if (wr_pass_en && slot == IW'(e)) pass_mem[waddr] <= b_q;
			if (cmd.take) begin
				rd_name_q[e] <= name_mem[raddr];
				rd_pass_q[e] <= pass_mem[raddr];
			end
		end

		always_ff @(posedge clk) begin
			if (wr_nlen_en && slot == IW'(e)) name_len_q[e] <= pos1;
			if (wr_plen_en && slot == IW'(e)) pass_len_q[e] <= pos1;
		end
	end

	assign ok         = ok_q;
	assign status     = status_q;
	assign user_count = count_q;

endmodule

FILE: design/credential_table_core.sv
// Credential table: one byte or part end per input transaction.
// Each transaction is latched when taken and evaluated once the output slot is
// free, which registers the result of a request it ends; no new one is taken
// meanwhile. The per-entry bank read is registered and compared on evaluation.
// Reset clears valid marks, user count and request state; banks and lengths
// are not cleared and no clearing pass runs.
module credential_table_core #(
	parameter int ENTRIES = ctab_pkg::ENTRIES_DEF,
	parameter int MAX_LEN = ctab_pkg::MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic       part,
	input  logic [7:0] data_byte,
	input  logic       empty_part,
	input  logic       last_of_part,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       ok,
	output logic [2:0] status,
	output logic [4:0] user_count
);

	ctab_pkg::ctab_cmd_t  cmd;
	ctab_pkg::ctab_stat_t stat;

	ctab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// the part flag is implied by the request phase
	ctab_dp #(
		.ENTRIES (ENTRIES),
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.data_byte    (data_byte),
		.empty_part   (empty_part),
		.last_of_part (last_of_part),
		.ok           (ok),
		.status       (status),
		.user_count   (user_count)
	);

endmodule
